FILE: sv/circle_waypoint_sequencer_core_macros.svh
// Assertion macros shared by the waypoint sequencer RTL.
`ifndef CIRCLE_WAYPOINT_SEQUENCER_CORE_MACROS_SVH
`define CIRCLE_WAYPOINT_SEQUENCER_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define CWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define CWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cws_pkg.sv
// Types, constants and trig table of the waypoint sequencer.
`timescale 1ns / 1ps
package cws_pkg;

  localparam int POS_W     = 32;
  localparam int RAD_W     = 23;
  localparam int THR_W     = 20;
  localparam int STEP_W    = 7;
  localparam int ANG_W     = 9;
  localparam int ANGX_W    = ANG_W + 1;
  localparam int TRIG_W    = 18;
  localparam int TRIG_FRAC = 16;
  localparam int TRIG_ONE  = 1 << TRIG_FRAC;
  localparam int K_W       = 20;
  localparam int MCW       = ((K_W > THR_W) ? K_W : THR_W) + 1;
  localparam int MPW       = (RAD_W > THR_W) ? RAD_W : THR_W;
  localparam int PROD_W    = MCW + 1 + MPW;
  localparam int OFF_W     = PROD_W - TRIG_FRAC;
  localparam int SUM_W     = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;
  localparam int CFG_W     = RAD_W;
  localparam int FULL_TURN = 360;
  localparam int HALF_TURN = 180;
  localparam int QUARTER   = 90;
  localparam int THREE_Q   = 270;
  localparam int SIN_N     = 91;
  localparam int SIN_IDX_W = $clog2(SIN_N);

  localparam logic [TRIG_W-2:0] SIN_Q [SIN_N] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61965, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  typedef enum logic [1:0] {
    CFG_RADIUS,
    CFG_THRESH,
    CFG_STEP,
    CFG_MODE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MUL_X,
    ST_MUL_Y,
    ST_EMIT,
    ST_DIFF,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_T
  } state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] meas_x;
    logic signed [POS_W-1:0] meas_y;
    logic signed [POS_W-1:0] meas_z;
    logic                    restart;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] target_x_out;
    logic signed [POS_W-1:0] target_y_out;
    logic signed [POS_W-1:0] target_z_out;
    logic [ANG_W-1:0]        angle_out;
    logic                    advanced;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic                  start;
    logic signed [MCW-1:0] mcand;
    logic [MPW-1:0]        mplier;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] product;
  } mul_rsp_t;

  function automatic logic [ANGX_W-1:0] deg_wrap(input logic [ANGX_W-1:0] v);
    logic [ANGX_W-1:0] r;
    if (v >= ANGX_W'(2 * FULL_TURN)) begin
      r = v - ANGX_W'(2 * FULL_TURN);
    end else if (v >= ANGX_W'(FULL_TURN)) begin
      r = v - ANGX_W'(FULL_TURN);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [ANGX_W-1:0] a_in);
    logic [ANGX_W-1:0]        a;
    logic [ANGX_W-1:0]        fold;
    logic                     neg;
    logic signed [TRIG_W-1:0] mag;
    a = deg_wrap(a_in);
    priority if (a <= ANGX_W'(QUARTER)) begin
      fold = a;
      neg  = 1'b0;
    end else if (a <= ANGX_W'(HALF_TURN)) begin
      fold = ANGX_W'(HALF_TURN) - a;
      neg  = 1'b0;
    end else if (a <= ANGX_W'(THREE_Q)) begin
      fold = a - ANGX_W'(HALF_TURN);
      neg  = 1'b1;
    end else begin
      fold = ANGX_W'(FULL_TURN) - a;
      neg  = 1'b1;
    end
    mag = signed'({1'b0, SIN_Q[fold[SIN_IDX_W-1:0]]});
    return neg ? -mag : mag;
  endfunction

endpackage

FILE: sv/cws_serial_mul.sv
// Bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier.
`timescale 1ns / 1ps
module cws_serial_mul
  import cws_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MPW);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MCW-1:0]      mcand_r, mcand_nxt;
  logic [MPW-1:0]      mplier_r, mplier_nxt;
  logic [MCW:0]        hi_r, hi_nxt;
  logic [MPW-1:0]      lo_r, lo_nxt;
  logic [MCW+1:0]      add;

  assign add = {hi_r[MCW], hi_r}
             + (mplier_r[0] ? {{2{mcand_r[MCW-1]}}, mcand_r} : {(MCW+2){1'b0}});

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    if (req.start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      mcand_nxt  = req.mcand;
      mplier_nxt = req.mplier;
      hi_nxt     = '0;
      lo_nxt     = '0;
    end else if (busy_r) begin
      hi_nxt     = add[MCW+1:1];
      lo_nxt     = {add[0], lo_r[MPW-1:1]};
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MPW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.product = signed'({hi_r, lo_r});

endmodule

FILE: sv/circle_waypoint_sequencer_core.sv
// Circle and cardioid waypoint sequencer: top level with control and datapath.
//
// Use: send one position request per tick on in_valid/in_stall (meas_x/y/z and
// restart). The first request after reset, or one with restart set, captures the
// position as origin and yields two results: the new setpoint (last 0), then the
// outcome of the reach test (last 1). Other requests yield one result (last 1).
// Results leave on out_valid/out_stall from an output register; while it holds
// a stalled result the block keeps working and waits only to load the next one.
// Registers are to be written on cfg_valid/cfg_ready only while the block is idle;
// the block itself does not enforce this. A request that misses the reach window
// goes straight to its result; inside the window its squared distance is tested,
// and the waypoint advances when that is below the squared threshold. One request
// is worked on at a time; the next one is taken the cycle after the last result
// is loaded. All products come from the shared bit-serial multiplier: two products
// per setpoint and three per squared-distance test.
// Reset: registers take their defaults, the angle clears and the next request
// captures the origin. in_stall stays high while a request is in work.
`timescale 1ns / 1ps
`include "circle_waypoint_sequencer_core_macros.svh"
module circle_waypoint_sequencer_core
  import cws_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  in_t            in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output out_t           out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  cfg_idx_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic signed [K_W-1:0]   ONE_K   = K_W'(TRIG_ONE);
  localparam logic [PROD_W-1:0]       HALF_P  = PROD_W'(TRIG_ONE / 2);
  localparam logic [POS_W-1:0]        POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0]        POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  function automatic logic [ANG_W-1:0] adv_angle(input logic [ANG_W-1:0] a,
                                                  input logic [STEP_W-1:0] s);
    logic [ANGX_W-1:0] t;
    t = ANGX_W'(a) + ANGX_W'(s);
    if (t > ANGX_W'(FULL_TURN)) begin
      t = t - ANGX_W'(FULL_TURN);
    end
    return t[ANG_W-1:0];
  endfunction

  function automatic logic [POS_W:0] abs_diff(input logic signed [POS_W-1:0] a,
                                              input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    d = (POS_W+1)'(a) - (POS_W+1)'(b);
    return d[POS_W] ? -d : d;
  endfunction

  function automatic logic [POS_W-1:0] place_pos(input logic signed [POS_W-1:0] org,
                                                 input logic signed [PROD_W-1:0] prod);
    logic [PROD_W-1:0]        rnd;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-POS_W:0]     top;
    logic [POS_W-1:0]         r;
    rnd = prod + HALF_P;
    sum = SUM_W'(org) + SUM_W'($signed(rnd[PROD_W-1:TRIG_FRAC]));
    top = sum[SUM_W-1:POS_W-1];
    if (top == '0 || top == '1) begin
      r = sum[POS_W-1:0];
    end else begin
      r = sum[SUM_W-1] ? POS_MIN : POS_MAX;
    end
    return r;
  endfunction

  state_t                  state_r, state_nxt;
  logic                    started_r, started_nxt;
  logic                    capture_r, capture_nxt;
  logic                    emit_adv_r, emit_adv_nxt;
  logic                    emit_last_r, emit_last_nxt;
  logic [ANG_W-1:0]        cur_angle_r, cur_angle_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [RAD_W-1:0]        radius_r, radius_nxt;
  logic [THR_W-1:0]        thresh_r, thresh_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    mode_r, mode_nxt;

  logic signed [POS_W-1:0] meas_x_r, meas_x_nxt;
  logic signed [POS_W-1:0] meas_y_r, meas_y_nxt;
  logic signed [POS_W-1:0] origin_x_r, origin_x_nxt;
  logic signed [POS_W-1:0] origin_y_r, origin_y_nxt;
  logic signed [POS_W-1:0] origin_z_r, origin_z_nxt;
  logic signed [POS_W-1:0] setpoint_x_r, setpoint_x_nxt;
  logic signed [POS_W-1:0] setpoint_y_r, setpoint_y_nxt;
  logic signed [K_W-1:0]   ky_r, ky_nxt;
  logic [THR_W-1:0]        dx_r, dx_nxt;
  logic [THR_W-1:0]        dy_r, dy_nxt;
  logic [PROD_W-1:0]       sum_r, sum_nxt;
  out_t                    out_data_r, out_data_nxt;

  logic [ANGX_W-1:0]        ang_1x, ang_2x;
  logic signed [TRIG_W-1:0] s1, c1, s2, c2;
  logic signed [K_W-1:0]    kx_c, ky_c;
  logic [POS_W:0]           dx_c, dy_c;
  logic                     within_c;
  logic                     out_free;
  logic                     mul_st_c;
  logic                     fin_load_c;
  mul_req_t                 mul_req;
  mul_rsp_t                 mul_rsp;

  cws_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  assign ang_1x = ANGX_W'(cur_angle_r);
  assign ang_2x = {cur_angle_r, 1'b0};
  assign s1 = sin_deg(ang_1x);
  assign c1 = sin_deg(ang_1x + ANGX_W'(QUARTER));
  assign s2 = sin_deg(ang_2x);
  assign c2 = sin_deg(ang_2x + ANGX_W'(QUARTER));

  always_comb begin
    if (mode_r) begin
      kx_c = (K_W'(c1) <<< 1) - K_W'(c2) - ONE_K;
      ky_c = (K_W'(s1) <<< 1) - K_W'(s2);
    end else begin
      kx_c = K_W'(c1) - ONE_K;
      ky_c = K_W'(s1);
    end
  end

  assign dx_c     = abs_diff(meas_x_r, setpoint_x_r);
  assign dy_c     = abs_diff(meas_y_r, setpoint_y_r);
  assign within_c = (dx_c < (POS_W+1)'(thresh_r)) && (dy_c < (POS_W+1)'(thresh_r));
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    started_nxt    = started_r;
    capture_nxt    = capture_r;
    emit_adv_nxt   = emit_adv_r;
    emit_last_nxt  = emit_last_r;
    cur_angle_nxt  = cur_angle_r;
    out_valid_nxt  = out_valid_r && out_stall;
    radius_nxt     = radius_r;
    thresh_nxt     = thresh_r;
    step_nxt       = step_r;
    mode_nxt       = mode_r;
    meas_x_nxt     = meas_x_r;
    meas_y_nxt     = meas_y_r;
    origin_x_nxt   = origin_x_r;
    origin_y_nxt   = origin_y_r;
    origin_z_nxt   = origin_z_r;
    setpoint_x_nxt = setpoint_x_r;
    setpoint_y_nxt = setpoint_y_r;
    ky_nxt         = ky_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    sum_nxt        = sum_r;
    out_data_nxt   = out_data_r;
    mul_req        = '0;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_nxt = cfg_data[RAD_W-1:0];
        CFG_THRESH: thresh_nxt = cfg_data[THR_W-1:0];
        CFG_STEP:   step_nxt   = cfg_data[STEP_W-1:0];
        CFG_MODE:   mode_nxt   = cfg_data[0];
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          meas_x_nxt = in_data.meas_x;
          meas_y_nxt = in_data.meas_y;
          if (in_data.restart || !started_r) begin
            origin_x_nxt  = in_data.meas_x;
            origin_y_nxt  = in_data.meas_y;
            origin_z_nxt  = in_data.meas_z;
            cur_angle_nxt = adv_angle(cur_angle_r, step_r);
            started_nxt   = 1'b1;
            capture_nxt   = 1'b1;
            state_nxt     = ST_TRIG;
          end else begin
            capture_nxt = 1'b0;
            state_nxt   = ST_DIFF;
          end
        end
      end
      ST_TRIG: begin
        ky_nxt         = ky_c;
        mul_req.start  = 1'b1;
        mul_req.mcand  = MCW'(kx_c);
        mul_req.mplier = MPW'(radius_r);
        state_nxt      = ST_MUL_X;
      end
      ST_MUL_X: begin
        if (mul_rsp.done) begin
          setpoint_x_nxt = place_pos(origin_x_r, mul_rsp.product);
          mul_req.start  = 1'b1;
          mul_req.mcand  = MCW'(ky_r);
          mul_req.mplier = MPW'(radius_r);
          state_nxt      = ST_MUL_Y;
        end
      end
      ST_MUL_Y: begin
        if (mul_rsp.done) begin
          setpoint_y_nxt = place_pos(origin_y_r, mul_rsp.product);
          emit_adv_nxt   = 1'b1;
          emit_last_nxt  = !capture_r;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.target_x_out  = setpoint_x_r;
          out_data_nxt.target_y_out  = setpoint_y_r;
          out_data_nxt.target_z_out  = origin_z_r;
          out_data_nxt.angle_out     = cur_angle_r;
          out_data_nxt.advanced      = emit_adv_r;
          out_data_nxt.last          = emit_last_r;
          if (emit_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            capture_nxt = 1'b0;
            state_nxt   = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        if (within_c) begin
          dx_nxt         = dx_c[THR_W-1:0];
          dy_nxt         = dy_c[THR_W-1:0];
          mul_req.start  = 1'b1;
          mul_req.mcand  = MCW'(dx_c[THR_W-1:0]);
          mul_req.mplier = MPW'(dx_c[THR_W-1:0]);
          state_nxt      = ST_SQ_X;
        end else begin
          emit_adv_nxt  = 1'b0;
          emit_last_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_SQ_X: begin
        if (mul_rsp.done) begin
          sum_nxt        = mul_rsp.product;
          mul_req.start  = 1'b1;
          mul_req.mcand  = MCW'(dy_r);
          mul_req.mplier = MPW'(dy_r);
          state_nxt      = ST_SQ_Y;
        end
      end
      ST_SQ_Y: begin
        if (mul_rsp.done) begin
          sum_nxt        = sum_r + mul_rsp.product;
          mul_req.start  = 1'b1;
          mul_req.mcand  = MCW'(thresh_r);
          mul_req.mplier = MPW'(thresh_r);
          state_nxt      = ST_SQ_T;
        end
      end
      ST_SQ_T: begin
        if (mul_rsp.done) begin
          if (sum_r < $unsigned(mul_rsp.product)) begin
            cur_angle_nxt = adv_angle(cur_angle_r, step_r);
            state_nxt     = ST_TRIG;
          end else begin
            emit_adv_nxt  = 1'b0;
            emit_last_nxt = 1'b1;
            state_nxt     = ST_EMIT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      capture_r   <= 1'b0;
      emit_adv_r  <= 1'b0;
      emit_last_r <= 1'b0;
      cur_angle_r <= '0;
      out_valid_r <= 1'b0;
      radius_r    <= RAD_W'(327680);
      thresh_r    <= THR_W'(13107);
      step_r      <= STEP_W'(5);
      mode_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      capture_r   <= capture_nxt;
      emit_adv_r  <= emit_adv_nxt;
      emit_last_r <= emit_last_nxt;
      cur_angle_r <= cur_angle_nxt;
      out_valid_r <= out_valid_nxt;
      radius_r    <= radius_nxt;
      thresh_r    <= thresh_nxt;
      step_r      <= step_nxt;
      mode_r      <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_x_r     <= meas_x_nxt;
    meas_y_r     <= meas_y_nxt;
    origin_x_r   <= origin_x_nxt;
    origin_y_r   <= origin_y_nxt;
    origin_z_r   <= origin_z_nxt;
    setpoint_x_r <= setpoint_x_nxt;
    setpoint_y_r <= setpoint_y_nxt;
    ky_r         <= ky_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    sum_r        <= sum_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign mul_st_c   = (state_r == ST_MUL_X) || (state_r == ST_MUL_Y) || (state_r == ST_SQ_X)
                   || (state_r == ST_SQ_Y) || (state_r == ST_SQ_T);
  assign fin_load_c = (state_r == ST_EMIT) && emit_last_r && out_free;

  `CWS_ASSERT_NOW(a_angle_range, started_r, cur_angle_r <= ANG_W'(FULL_TURN), "angle too big")
  `CWS_ASSERT_NOW(a_mul_done_state, mul_rsp.done, mul_st_c, "product done outside multiply")
  `CWS_ASSERT_NOW(a_hold_is_last, out_valid_r && !out_data_r.advanced, out_data_r.last, "hold not last")
  `CWS_ASSERT_NEXT(a_last_to_idle, fin_load_c, state_r == ST_IDLE, "final result did not end request")

endmodule
